// ===== hdl/bfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and constants of the best-fit partition allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

   // item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   // field widths fixed by the interface
   localparam int unsigned IDX_FIELD_W  = 4;
   localparam int unsigned SIZE_FIELD_W = 16;
   localparam int unsigned TOTAL_W      = 20;
   localparam int unsigned CSR_W        = 5;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX       = '1;
   localparam logic [CSR_W-1:0]   CSR_COUNT_RESET = 5'd16;

   // input beat
   typedef struct packed {
      logic                    mode;
      logic [IDX_FIELD_W-1:0]  partition_index;
      logic [SIZE_FIELD_W-1:0] size_value;
   } bfpa_req_type;

   // result beat
   typedef struct packed {
      logic                   granted;
      logic [IDX_FIELD_W-1:0] block_index;
      logic [TOTAL_W-1:0]     total_free;
   } bfpa_rsp_type;

   // control from the sequencer to the scan unit
   typedef struct packed {
      logic clear;
      logic beat;
   } bfpa_scan_ctl_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } bfpa_state_type;

endpackage

// ===== hdl/bfpa_store.sv =====
// ----------------------------------------------------------------------------
// bfpa_store
// Free-size memory: one write port, one registered read port. Entries not
// written since reset read as zero through a per-entry valid bit.
// ----------------------------------------------------------------------------
module bfpa_store #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned WIDTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // memory array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // unwritten entries read as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== hdl/bfpa_scan.sv =====
// ----------------------------------------------------------------------------
// bfpa_scan
// Best-fit search and free-size accumulation over one read beat per cycle.
// ----------------------------------------------------------------------------
module bfpa_scan
   import bfpa_pkg::*;
#(
   parameter int unsigned WIDTH  = 16,
   parameter int unsigned ADDR_W = 4,
   parameter int unsigned SUM_W  = 21
) (
   input  logic              clock,
   input  logic              reset,
   input  bfpa_scan_ctl_type ctl,
   input  logic [ADDR_W-1:0] beat_idx,
   input  logic [WIDTH-1:0]  beat_data,
   input  logic [WIDTH-1:0]  req_size,
   output logic              found,
   output logic [ADDR_W-1:0] best_idx,
   output logic [WIDTH-1:0]  best_diff,
   output logic [SUM_W-1:0]  sum
);

   logic              found_ff, found_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic [WIDTH-1:0]  best_diff_ff, best_diff_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              fits;
   logic [WIDTH-1:0]  diff;
   logic              take;

   // compare this beat against the best so far
   always_comb begin
      fits = beat_data >= req_size;
      diff = beat_data - req_size;
      take = ctl.beat && fits && (!found_ff || (diff < best_diff_ff));
   end

   // next values
   always_comb begin
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_diff_in = best_diff_ff;
      sum_in       = sum_ff;
      if (ctl.clear) begin
         found_in     = 1'b0;
         best_idx_in  = '0;
         best_diff_in = '0;
         sum_in       = '0;
      end else if (ctl.beat) begin
         sum_in = sum_ff + SUM_W'(beat_data);
         if (take) begin
            found_in     = 1'b1;
            best_idx_in  = beat_idx;
            best_diff_in = diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         sum_ff   <= '0;
      end else begin
         found_ff <= found_in;
         sum_ff   <= sum_in;
      end
      best_idx_ff  <= best_idx_in;
      best_diff_ff <= best_diff_in;
   end

   assign found     = found_ff;
   assign best_idx  = best_idx_ff;
   assign best_diff = best_diff_ff;
   assign sum       = sum_ff;

endmodule

// ===== hdl/best_fit_partition_allocator_core.sv =====
// ----------------------------------------------------------------------------
// best_fit_partition_allocator_core
// Best-fit allocator over a table of partition free sizes kept in memory.
//
//   channel  ports                     direction  flow
//   request  start, busy, req_beat     in         start while busy low
//   result   rsp_valid, rsp_beat       out        one-cycle strobe
//   config   csr_we, csr_wdata         in         write, no wait
//
// An item passes from the accept edge through the scan, a drain state and a
// finish state to the edge that takes its result; the scan is skipped with
// no partitions in use. The scan reads the memory one entry per cycle
// through its single read port, the drain state empties the read pipe, and
// the winner is written back at the edge that raises the result strobe. busy is
// low again in the cycle the result is shown. Reset clears the table through
// per-entry valid bits. The result side has no back-pressure.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator_core
   import bfpa_pkg::*;
#(
   parameter int unsigned NUM_PARTITIONS = 16,
   parameter int unsigned SIZE_BITS      = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bfpa_req_type       req_beat,
   output logic               rsp_valid,
   output bfpa_rsp_type       rsp_beat,
   input  logic               csr_we,
   input  logic [CSR_W-1:0]   csr_wdata
);

   localparam int unsigned ADDR_W = $clog2(NUM_PARTITIONS);
   localparam int unsigned CNT_W  = $clog2(NUM_PARTITIONS + 1);
   localparam int unsigned SUM_W  = SIZE_BITS + ADDR_W + 1;

   bfpa_state_type    state_ff, state_in;
   logic [CSR_W-1:0]  csr_count_ff;
   logic [CNT_W-1:0]  n_now;
   logic [CNT_W-1:0]  n_ff;
   logic              mode_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [CNT_W-1:0]  rd_addr_ff, rd_addr_in;
   logic              beat_ff;
   logic [ADDR_W-1:0] beat_idx_ff;
   logic              rsp_valid_ff;
   bfpa_rsp_type      rsp_ff;

   logic              accept;
   logic              load_hit;
   logic              last_issue;
   logic              rd_en;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic [SIZE_BITS-1:0] rd_data;
   logic [SIZE_BITS-1:0] req_size;
   bfpa_scan_ctl_type scan_ctl;
   logic              found;
   logic [ADDR_W-1:0] best_idx;
   logic [SIZE_BITS-1:0] best_diff;
   logic [SUM_W-1:0]  sum;
   logic              grant;
   logic [SUM_W-1:0]  sum_after;
   bfpa_rsp_type      rsp_in;

   // partitions in use, limited to the table depth
   always_comb begin
      if (32'(csr_count_ff) > 32'(NUM_PARTITIONS)) begin
         n_now = CNT_W'(NUM_PARTITIONS);
      end else begin
         n_now = CNT_W'(csr_count_ff);
      end
   end

   assign accept   = start && (state_ff == ST_IDLE);
   assign req_size = SIZE_BITS'(req_beat.size_value);
   assign load_hit = accept && (req_beat.mode == MODE_LOAD)
                     && (32'(req_beat.partition_index) < 32'(n_now));
   assign last_issue = (rd_addr_ff == (n_ff - CNT_W'(1)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (n_now == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // result of the finished scan
   always_comb begin
      grant     = (mode_ff == MODE_ALLOC) && found;
      sum_after = sum - (grant ? SUM_W'(size_ff) : '0);
      rsp_in.granted     = grant;
      rsp_in.block_index = grant ? IDX_FIELD_W'(best_idx) : '0;
      if (64'(sum_after) > 64'(TOTAL_MAX)) begin
         rsp_in.total_free = TOTAL_MAX;
      end else begin
         rsp_in.total_free = TOTAL_W'(sum_after);
      end
   end

   // outputs of the sequencer
   always_comb begin
      rd_en          = 1'b0;
      rd_addr_in     = rd_addr_ff;
      wr_en          = 1'b0;
      wr_addr        = best_idx;
      wr_data        = best_diff;
      scan_ctl.clear = 1'b0;
      scan_ctl.beat  = beat_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_addr_in     = '0;
            scan_ctl.clear = accept;
            wr_en          = load_hit;
            wr_addr        = ADDR_W'(req_beat.partition_index);
            wr_data        = req_size;
         end
         ST_SCAN: begin
            rd_en      = 1'b1;
            rd_addr_in = rd_addr_ff + CNT_W'(1);
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            wr_en = grant;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_count_ff <= CSR_COUNT_RESET;
         rd_addr_ff   <= '0;
         beat_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_addr_ff   <= rd_addr_in;
         beat_ff      <= rd_en;
         rsp_valid_ff <= (state_ff == ST_FINISH);
         if (csr_we) begin
            csr_count_ff <= csr_wdata;
         end
      end
   end

   // item and payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_beat.mode;
         size_ff <= req_size;
         n_ff    <= n_now;
      end
      beat_idx_ff <= rd_addr_ff[ADDR_W-1:0];
      if (state_ff == ST_FINISH) begin
         rsp_ff <= rsp_in;
      end
   end

   bfpa_store #(
      .DEPTH  (NUM_PARTITIONS),
      .WIDTH  (SIZE_BITS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   bfpa_scan #(
      .WIDTH  (SIZE_BITS),
      .ADDR_W (ADDR_W),
      .SUM_W  (SUM_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .beat_idx  (beat_idx_ff),
      .beat_data (rd_data),
      .req_size  (size_ff),
      .found     (found),
      .best_idx  (best_idx),
      .best_diff (best_diff),
      .sum       (sum)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   // a result strobe always follows the finish cycle
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_FINISH))
      else $error("result strobe without a finish cycle");

   // loads never grant
   a_load_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.granted) |-> (mode_ff == MODE_ALLOC))
      else $error("grant on a load beat");

   // the read address stays inside the partitions in use
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rd_addr_ff < n_ff))
      else $error("scan read beyond partitions in use");

   // the winner write-back happens only with a found entry
   a_write_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && wr_en) |-> found)
      else $error("write-back without a fitting partition");

endmodule
